// ===== rtl/core/suffix_aligned_consensus_top_defines.svh =====
// Assertion macros for the suffix-aligned consensus block.
// Used by suffix_aligned_consensus_top; needs aclk and aresetn in scope.
`ifndef SUFFIX_ALIGNED_CONSENSUS_TOP_DEFINES_SVH
`define SUFFIX_ALIGNED_CONSENSUS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sac_pkg.sv =====
// Shared types, codes and helper functions for the suffix-aligned consensus block.
// No dependencies; imported by sac_front, sac_back and the top level.
package sac_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 6;
    localparam int DEPTH_OUT_W = 7;
    localparam int SYM_W       = 2;
    localparam int NSYM_W      = 3;
    localparam int NUM_CODES   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // Opcodes
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_THREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_IN_USE = 3'd4;

    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
        logic [POS_W-1:0]  query_pos;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]      consensus_char;
        logic                   pos_valid;
        logic [DEPTH_OUT_W-1:0] deepest_length;
    } out_t;

    typedef struct packed {
        logic [NUM_CODES-1:0][CHAR_W-1:0] sym_code;
        logic [NSYM_W-1:0]                symbols_in_use;
    } cfg_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic             is_query;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [POS_W-1:0] pos;
    } cmd_t;

    // Back-end status seen by the top level
    typedef struct packed {
        logic clearing;
        logic query_sel;
    } status_t;

    // Number of symbols actually compared: 0 acts as 1, above the alphabet clamps
    function automatic logic [NSYM_W-1:0] active_symbols(input logic [NSYM_W-1:0] n,
                                                         input logic [NSYM_W-1:0] alpha);
        logic [NSYM_W-1:0] r;
        r = n;
        if (n == '0) begin
            r = NSYM_W'(1);
        end else if (n > alpha) begin
            r = alpha;
        end
        return r;
    endfunction

    // Character code to symbol index; lowest match wins, no match gives symbol 0
    function automatic logic [SYM_W-1:0] map_symbol(
        input logic [CHAR_W-1:0]                c,
        input logic [NUM_CODES-1:0][CHAR_W-1:0] codes,
        input logic [NSYM_W-1:0]                n
    );
        logic [SYM_W-1:0] sym;
        sym = '0;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (NSYM_W'(k) < n && codes[k] == c) begin
                sym = SYM_W'(k);
            end
        end
        return sym;
    endfunction

endpackage

// ===== rtl/core/suffix_aligned_consensus_top.sv =====
// Top level of the suffix-aligned consensus block: configuration registers,
// front end, back end. Depends on sac_pkg, sac_front, sac_back and the defines header.
//
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    sac_pkg::in_t  (opcode, char_in, last_char, query_pos)
// m_       out        m_valid/m_ready    sac_pkg::out_t (consensus_char, pos_valid, deepest_length)
// cfg_     in         cfg_we             cfg_index selects the register, cfg_wdata the value
//
// A plain character is taken by the back end in idle. A closing character starts a walk that
// reads, bumps and writes back the count row of each buffered position, newest character first.
// After reset a clearing pass zeroes every count-table row; s_ready stays low meanwhile.
// A two-entry command queue lets input transfers continue while the back end walks,
// and the output register holds a result while the next items are taken.
`include "suffix_aligned_consensus_top_defines.svh"

module suffix_aligned_consensus_top #(
    parameter int MAX_LEN     = 64,
    parameter int ALPHABET    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sac_pkg::in_t                          s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sac_pkg::out_t                         m_payload
);
    import sac_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    logic    cmd_valid, cmd_ready;
    status_t status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sym_code[0]    <= 8'd65;
            cfg_reg.sym_code[1]    <= 8'd67;
            cfg_reg.sym_code[2]    <= 8'd71;
            cfg_reg.sym_code[3]    <= 8'd84;
            cfg_reg.symbols_in_use <= 3'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SYMBOL_ZERO:    cfg_reg.sym_code[0]    <= cfg_wdata;
                REG_SYMBOL_ONE:     cfg_reg.sym_code[1]    <= cfg_wdata;
                REG_SYMBOL_TWO:     cfg_reg.sym_code[2]    <= cfg_wdata;
                REG_SYMBOL_THREE:   cfg_reg.sym_code[3]    <= cfg_wdata;
                REG_SYMBOLS_IN_USE: cfg_reg.symbols_in_use <= cfg_wdata[NSYM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sac_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept_en (!status.clearing),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sac_back #(
        .MAX_LEN     (MAX_LEN),
        .ALPHABET    (ALPHABET),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .status    (status)
    );

    // No input transfer while the count table is being cleared
    `SAC_ASSERT_NOW(a_no_accept_in_clear, status.clearing, !s_ready, "input taken during clear")
    // The clearing pass runs once per reset
    `SAC_ASSERT_NEXT(a_clear_once, !status.clearing, !status.clearing, "clear restarted")
    // A result appears only after the query select step
    `SAC_ASSERT_NOW(a_result_from_query, $rose(m_valid), $past(status.query_sel),
        "result without query")

endmodule

// ===== rtl/core/sac_front.sv =====
// Front end: accepts input transfers, maps characters to symbols, queues commands.
// Depends on sac_pkg.
module sac_front #(
    parameter int ALPHABET = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  sac_pkg::cfg_t   cfg,
    input  logic            accept_en,
    input  logic            s_valid,
    output logic            s_ready,
    input  sac_pkg::in_t    s_payload,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output sac_pkg::cmd_t   cmd
);
    import sac_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              new_cmd;
    logic [NSYM_W-1:0] n_act;

    // Classify the incoming item
    always_comb begin
        n_act            = active_symbols(cfg.symbols_in_use, NSYM_W'(ALPHABET));
        new_cmd.is_query = (s_payload.opcode == OP_QUERY);
        new_cmd.sym      = map_symbol(s_payload.char_in, cfg.sym_code, n_act);
        new_cmd.last     = s_payload.last_char;
        new_cmd.pos      = s_payload.query_pos;
    end

    assign s_ready   = accept_en && (count_reg != QCNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/core/sac_back.sv =====
// Back end: character buffer, count table with clearing pass, sequence walk,
// query argmax and output register. Depends on sac_pkg.
module sac_back #(
    parameter int MAX_LEN     = 64,
    parameter int ALPHABET    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sac_pkg::cfg_t     cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  sac_pkg::cmd_t     cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output sac_pkg::out_t     m_payload,
    output sac_pkg::status_t  status
);
    import sac_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = (POS_W > FILL_W) ? POS_W : FILL_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_LEN - 1);
    localparam logic [FILL_W-1:0] MAX_FILL  = FILL_W'(MAX_LEN);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_QSEL  = 2'd3;

    typedef logic [ALPHABET-1:0][COUNT_WIDTH-1:0] row_t;

    // Memories
    logic [SYM_W-1:0] buf_mem [MAX_LEN];
    row_t             row_mem [MAX_LEN];
    logic [SYM_W-1:0] buf_q_reg;
    row_t             row_q_reg;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] widx_reg, widx_next;
    logic [FILL_W-1:0] walk_left_reg, walk_left_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] deepest_reg, deepest_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] p1_idx_reg, p1_idx_next;
    logic              q_in_range_reg, q_in_range_next;
    logic              q_pos_valid_reg, q_pos_valid_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              buf_we, buf_re, row_we, row_re;
    logic [ADDR_W-1:0] row_raddr, row_waddr;
    row_t              row_wdata, bumped;
    logic [FILL_W-1:0] fill_inc;
    logic [NSYM_W-1:0] n_act;
    logic [SYM_W-1:0]  best;
    logic [COUNT_WIDTH-1:0] best_cnt;
    logic              pos_in_range;

    // Saturating bump of the counted symbol in the row just read
    always_comb begin
        for (int k = 0; k < ALPHABET; k++) begin
            if (buf_q_reg == SYM_W'(k) && row_q_reg[k] != '1) begin
                bumped[k] = row_q_reg[k] + COUNT_WIDTH'(1);
            end else begin
                bumped[k] = row_q_reg[k];
            end
        end
    end

    // Argmax over the active symbols, ties to the lowest index
    always_comb begin
        n_act    = active_symbols(cfg.symbols_in_use, NSYM_W'(ALPHABET));
        best     = '0;
        best_cnt = '0;
        for (int k = 0; k < ALPHABET; k++) begin
            if (NSYM_W'(k) < n_act && row_q_reg[k] > best_cnt) begin
                best     = SYM_W'(k);
                best_cnt = row_q_reg[k];
            end
        end
        if (!q_in_range_reg) begin
            best = '0;
        end
    end

    assign fill_inc     = (fill_reg == MAX_FILL) ? fill_reg : fill_reg + 1'b1;
    assign pos_in_range = CMP_W'(cmd.pos) < CMP_W'(MAX_LEN);

    // Control sequencer
    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        widx_next        = widx_reg;
        walk_left_next   = walk_left_reg;
        fill_next        = fill_reg;
        deepest_next     = deepest_reg;
        p1_valid_next    = p1_valid_reg;
        p1_idx_next      = p1_idx_reg;
        q_in_range_next  = q_in_range_reg;
        q_pos_valid_next = q_pos_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        buf_we           = 1'b0;
        buf_re           = 1'b0;
        row_we           = 1'b0;
        row_re           = 1'b0;
        row_raddr        = widx_reg;
        row_waddr        = p1_idx_reg;
        row_wdata        = bumped;
        cmd_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                row_we       = 1'b1;
                row_waddr    = clr_idx_reg;
                row_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (!cmd.is_query) begin
                        buf_we  = 1'b1;
                        wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                        if (cmd.last) begin
                            // newest entry first, walking back through the buffer
                            rp_next        = wp_reg;
                            widx_next      = '0;
                            walk_left_next = fill_inc;
                            fill_next      = '0;
                            if (fill_inc > deepest_reg) begin
                                deepest_next = fill_inc;
                            end
                            state_next = ST_WALK;
                        end else begin
                            fill_next = fill_inc;
                        end
                    end else begin
                        q_in_range_next  = pos_in_range;
                        q_pos_valid_next = CMP_W'(cmd.pos) < CMP_W'(deepest_reg);
                        row_re           = pos_in_range;
                        row_raddr        = ADDR_W'(cmd.pos);
                        state_next       = ST_QSEL;
                    end
                end
            end
            ST_WALK: begin
                // write back the row read last cycle
                if (p1_valid_reg) begin
                    row_we = 1'b1;
                end
                if (walk_left_reg != '0) begin
                    buf_re         = 1'b1;
                    row_re         = 1'b1;
                    rp_next        = (rp_reg == '0) ? LAST_ADDR : rp_reg - 1'b1;
                    widx_next      = widx_reg + 1'b1;
                    walk_left_next = walk_left_reg - 1'b1;
                    p1_valid_next  = 1'b1;
                    p1_idx_next    = widx_reg;
                end else begin
                    p1_valid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            ST_QSEL: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.consensus_char = cfg.sym_code[best];
                    m_data_next.pos_valid      = q_pos_valid_reg;
                    m_data_next.deepest_length = DEPTH_OUT_W'(deepest_reg);
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            wp_reg        <= '0;
            walk_left_reg <= '0;
            fill_reg      <= '0;
            deepest_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            wp_reg        <= wp_next;
            walk_left_reg <= walk_left_next;
            fill_reg      <= fill_next;
            deepest_reg   <= deepest_next;
            p1_valid_reg  <= p1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rp_reg          <= rp_next;
        widx_reg        <= widx_next;
        p1_idx_reg      <= p1_idx_next;
        q_in_range_reg  <= q_in_range_next;
        q_pos_valid_reg <= q_pos_valid_next;
        m_data_reg      <= m_data_next;
    end

    // Character buffer: circular, one write and one registered read
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[wp_reg] <= cmd.sym;
        end
        if (buf_re) begin
            buf_q_reg <= buf_mem[rp_reg];
        end
    end

    // Count table: one row per position, one write and one registered read
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re) begin
            row_q_reg <= row_mem[row_raddr];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload        = m_data_reg;
    assign status.clearing  = (state_reg == ST_CLEAR);
    assign status.query_sel = (state_reg == ST_QSEL);

endmodule

// ===== test/sac_consensus_checker.sv =====
// Checker for suffix_aligned_consensus_top: tracks register writes, predicts each
// consensus query result and compares it with the m_ channel. Depends on sac_pkg.
module sac_consensus_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  sac_pkg::in_t                   s_payload,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  sac_pkg::out_t                  m_payload,
    output int                             err_count,
    output int                             queries_open
);
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    localparam int PROFILE_LEN = 64;
    localparam int NUM_SYMS    = 4;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    // Shadow copy of the configuration
    logic [CHAR_W-1:0] sym_code [NUM_CODES];
    logic [NSYM_W-1:0] sym_limit;

    // Shadow copy of the profile state
    logic [SYM_W-1:0]  seq_syms   [PROFILE_LEN];
    int unsigned       seq_fill;
    logic [15:0]       sym_counts [PROFILE_LEN][NUM_SYMS];
    int unsigned       deepest;

    out_t consensus_due [$];

    function automatic int unsigned symbols_compared();
        int unsigned n;
        n = sym_limit;
        if (n < 1) n = 1;
        if (n > NUM_SYMS) n = NUM_SYMS;
        return n;
    endfunction

    // Lowest matching symbol wins; no match falls back to symbol 0
    function automatic logic [SYM_W-1:0] symbol_of(logic [CHAR_W-1:0] c);
        int unsigned n;
        n = symbols_compared();
        for (int k = 0; k < n; k++) begin
            if (sym_code[k] == c) return SYM_W'(k);
        end
        return '0;
    endfunction

    // Shift in one character; on the final one, bump counts position by position
    task automatic profile_char(logic [CHAR_W-1:0] c, logic last);
        for (int i = PROFILE_LEN - 1; i > 0; i--) begin
            seq_syms[i] = seq_syms[i-1];
        end
        seq_syms[0] = symbol_of(c);
        if (seq_fill < PROFILE_LEN) seq_fill++;
        if (last) begin
            for (int i = 0; i < seq_fill; i++) begin
                if (sym_counts[i][seq_syms[i]] != COUNT_TOP) begin
                    sym_counts[i][seq_syms[i]]++;
                end
            end
            if (seq_fill > deepest) deepest = seq_fill;
            seq_fill = 0;
        end
    endtask

    function automatic out_t consensus_at(logic [POS_W-1:0] pos);
        out_t        r;
        int unsigned best;
        logic [15:0] best_cnt;
        int unsigned n;
        best     = 0;
        best_cnt = '0;
        n        = symbols_compared();
        for (int k = 0; k < n; k++) begin
            if (sym_counts[pos][k] > best_cnt) begin
                best_cnt = sym_counts[pos][k];
                best     = k;
            end
        end
        r.consensus_char = sym_code[best];
        r.pos_valid      = (pos < deepest);
        r.deepest_length = DEPTH_OUT_W'(deepest);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            sym_code[0] = 8'd65;
            sym_code[1] = 8'd67;
            sym_code[2] = 8'd71;
            sym_code[3] = 8'd84;
            sym_limit   = 3'd4;
            seq_fill    = 0;
            deepest     = 0;
            for (int i = 0; i < PROFILE_LEN; i++) begin
                seq_syms[i] = '0;
                for (int k = 0; k < NUM_SYMS; k++) sym_counts[i][k] = '0;
            end
            consensus_due.delete();
        end else begin
            // Register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_SYMBOL_ZERO:    sym_code[0] = cfg_wdata;
                    REG_SYMBOL_ONE:     sym_code[1] = cfg_wdata;
                    REG_SYMBOL_TWO:     sym_code[2] = cfg_wdata;
                    REG_SYMBOL_THREE:   sym_code[3] = cfg_wdata;
                    REG_SYMBOLS_IN_USE: sym_limit   = cfg_wdata[NSYM_W-1:0];
                    default: ;
                endcase
            end

            // Result transfer against the oldest expectation
            if (m_valid && m_ready) begin
                if (consensus_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, got char %0h %s %0d %s %0d",
                             $time, m_payload.consensus_char, "valid", m_payload.pos_valid,
                             "depth", m_payload.deepest_length);
                    err_count++;
                end else begin
                    want = consensus_due.pop_front();
                    if (m_payload.consensus_char !== want.consensus_char) begin
                        $display("%0t consensus_char mismatch: expected %0h, got %0h",
                                 $time, want.consensus_char, m_payload.consensus_char);
                        err_count++;
                    end
                    if (m_payload.pos_valid !== want.pos_valid) begin
                        $display("%0t pos_valid mismatch: expected %0d, got %0d",
                                 $time, want.pos_valid, m_payload.pos_valid);
                        err_count++;
                    end
                    if (m_payload.deepest_length !== want.deepest_length) begin
                        $display("%0t deepest_length mismatch: expected %0d, got %0d",
                                 $time, want.deepest_length, m_payload.deepest_length);
                        err_count++;
                    end
                end
            end

            // Input transfer
            if (s_valid && s_ready) begin
                if (s_payload.opcode == OP_QUERY) begin
                    consensus_due.insert(consensus_due.size(),
                                         consensus_at(s_payload.query_pos));
                end else begin
                    profile_char(s_payload.char_in, s_payload.last_char);
                end
            end
        end
        queries_open = consensus_due.size();
    end

endmodule

// ===== test/tb_suffix_aligned_consensus_top.sv =====
// Testbench top for suffix_aligned_consensus_top: clock, reset, register writes,
// character and query stimulus, verdict. Depends on sac_pkg and sac_consensus_checker.
module tb_suffix_aligned_consensus_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 320;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_payload;

    int err_count;
    int queries_open;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [CHAR_W-1:0] cur_code [NUM_CODES];

    always #5 aclk = ~aclk;

    suffix_aligned_consensus_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    sac_consensus_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .err_count    (err_count),
        .queries_open (queries_open)
    );

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Overall time limit
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic in_t char_item(logic [CHAR_W-1:0] c, logic last);
        in_t p;
        p.opcode    = OP_CHAR;
        p.char_in   = c;
        p.last_char = last;
        p.query_pos = POS_W'($urandom);
        return p;
    endfunction

    function automatic in_t query_item(logic [POS_W-1:0] pos);
        in_t p;
        p.opcode    = OP_QUERY;
        p.char_in   = CHAR_W'($urandom);
        p.last_char = 1'($urandom);
        p.query_pos = pos;
        return p;
    endfunction

    // Mostly configured codes, sometimes any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(99) < 78) return cur_code[$urandom_range(NUM_CODES - 1)];
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(9);
        if (r < 6) return POS_W'($urandom_range(15));
        if (r < 9) return POS_W'($urandom_range(63));
        return ($urandom_range(1) != 0) ? POS_W'(63) : POS_W'(0);
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // following the transfer, with valid still high
    task automatic send_item(in_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = p;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off until every query result is back and the back end has settled
    task automatic drain();
        s_valid = 1'b0;
        while (queries_open != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(logic [CHAR_W-1:0] c0, logic [CHAR_W-1:0] c1,
                                 logic [CHAR_W-1:0] c2, logic [CHAR_W-1:0] c3,
                                 logic [CFG_DATA_W-1:0] nsym);
        drain();
        cfg_write(REG_SYMBOL_ZERO, c0);
        cfg_write(REG_SYMBOL_ONE, c1);
        cfg_write(REG_SYMBOL_TWO, c2);
        cfg_write(REG_SYMBOL_THREE, c3);
        cfg_write(REG_SYMBOLS_IN_USE, nsym);
        cur_code[0] = c0;
        cur_code[1] = c1;
        cur_code[2] = c2;
        cur_code[3] = c3;
        @(negedge aclk);
    endtask

    // Random traffic: mostly whole sequences, some query bursts and stray items
    task automatic random_phase(int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 68) begin
                r = $urandom_range(99);
                if (r < 70) len = $urandom_range(10, 1);
                else if (r < 95) len = $urandom_range(64, 11);
                else len = $urandom_range(90, 65);
                for (int i = 0; i < len; i++) begin
                    send_item(char_item(pick_char(), (i == len - 1)));
                    if ($urandom_range(99) < 4) begin
                        send_item(query_item(pick_pos()));
                        sent++;
                    end
                end
                sent += len;
            end else if (r < 94) begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++) send_item(query_item(pick_pos()));
                sent += len;
            end else if (r < 98) begin
                // unterminated run that merges into the next sequence
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++) send_item(char_item(CHAR_W'($urandom), 1'b0));
                sent += len;
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        cur_code[0] = 8'd65;
        cur_code[1] = 8'd67;
        cur_code[2] = 8'd71;
        cur_code[3] = 8'd84;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Sender 27 percent idle, receiver 51
        send_idle_pct = 27;
        recv_idle_pct = 51;

        // Indexes past the last register are written once and must do nothing
        for (int r = int'(REG_SYMBOLS_IN_USE) + 1; r < (1 << CFG_IDX_W); r++) begin
            cfg_write(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
        end
        apply_setting(8'd65, 8'd67, 8'd71, 8'd84, 8'd4);

        // Directed: empty table, unmatched codes, byte extremes, deep positions
        send_item(query_item(POS_W'(0)));
        send_item(char_item(8'h00, 1'b0));
        send_item(char_item(8'd67, 1'b0));
        send_item(char_item(8'd71, 1'b0));
        send_item(char_item(8'hFF, 1'b0));
        send_item(char_item(8'd84, 1'b1));
        for (int p = 0; p <= 5; p++) send_item(query_item(POS_W'(p)));
        send_item(query_item(POS_W'(63)));
        send_item(char_item(8'd71, 1'b1));
        send_item(query_item(POS_W'(0)));
        send_item(query_item(POS_W'(1)));

        // Code extremes
        apply_setting(8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFC);
        random_phase(PHASE_ITEMS);

        // Duplicate codes
        apply_setting(8'd65, 8'd65, 8'd67, 8'd67, 8'h03);
        random_phase(PHASE_ITEMS);

        // Sender 51 percent idle, receiver 27
        send_idle_pct = 51;
        recv_idle_pct = 27;

        // Zero symbols in use acts as one
        apply_setting(CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                      CHAR_W'($urandom), 8'h00);
        random_phase(PHASE_ITEMS);

        // Above the alphabet clamps to four
        apply_setting(CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                      CHAR_W'($urandom), 8'hFF);
        random_phase(PHASE_ITEMS);

        // No idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                      CHAR_W'($urandom), CFG_DATA_W'($urandom_range(3, 1)));
        random_phase(PHASE_ITEMS);

        drain();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
